@@ rtl/core/aes128_ctr_stream_cipher_unit_macros.svh @@
// Assertion macros used by the AES-128 CTR stream cipher RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef AES128_CTR_STREAM_CIPHER_UNIT_MACROS_SVH
`define AES128_CTR_STREAM_CIPHER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked outside reset
`define AC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aesctr check failed");
// next-cycle implication, checked outside reset
`define AC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aesctr check failed");
`else
`define AC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define AC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/aesctr_pkg.sv @@
// Shared types, constants and AES round functions for the CTR cipher.
// No dependencies.
`default_nettype none

package aesctr_pkg;

  localparam int AC_QUEUE_DEPTH = 4;
  localparam int AC_ROUNDS      = 10;

  typedef enum logic [1:0] {
    CFG_KEY_HIGH = 2'd0,
    CFG_KEY_LOW  = 2'd1,
    CFG_NONCE    = 2'd2
  } cfg_reg_t;

  // one classified word waiting for the back end
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [3:0]  pos;
    logic [63:0] ctr;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } aes_stat_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] r;
    unique case (rnd)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // next round key; byte 0 of the key sits in bits 127:120
  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] tmp;
    logic [31:0] n0, n1, n2, n3;
    tmp = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    n0  = k[127:96] ^ tmp;
    n1  = k[95:64] ^ n0;
    n2  = k[63:32] ^ n1;
    n3  = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // SubBytes, ShiftRows, MixColumns (skipped in the last round), AddRoundKey
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last_rnd);
    logic [7:0]   sb [16];
    logic [7:0]   t  [16];
    logic [7:0]   b0, b1, b2, b3, all;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) sb[i] = s[127 - 8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[c*4 + r] = SBOX[sb[((c + r) & 3)*4 + r]];
    if (!last_rnd) begin
      for (int c = 0; c < 4; c++) begin
        b0 = t[c*4]; b1 = t[c*4 + 1]; b2 = t[c*4 + 2]; b3 = t[c*4 + 3];
        all = b0 ^ b1 ^ b2 ^ b3;
        t[c*4]     = b0 ^ all ^ xtime(b0 ^ b1);
        t[c*4 + 1] = b1 ^ all ^ xtime(b1 ^ b2);
        t[c*4 + 2] = b2 ^ all ^ xtime(b2 ^ b3);
        t[c*4 + 3] = b3 ^ all ^ xtime(b3 ^ b0);
      end
    end
    for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = t[i];
    return o ^ rk;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/aes128_ctr_stream_cipher_unit.sv @@
// AES-128 counter-mode byte stream cipher, one word in and one word out.
// Input words arrive on in_* (tdata = byte, tuser = first of message,
// tlast = last of message); results leave on out_* (tdata = byte,
// tlast = copy of the input tlast). The same transform encrypts and decrypts.
// Keystream block = AES-128(key, nonce || 64-bit little-endian counter).
// Write key_high (0), key_low (1) and nonce (2) on cfg_* while idle; a write
// is registered, cfg_ready is always high, other indexes are dropped.
// The output word is registered as a word leaves the queue. The first word of
// a block waits for the 10-round AES engine (one round a cycle), which starts
// only when that word reaches the queue head; later words reuse its result.
// Inside a block the unit passes 1 word per cycle while out_tready is high;
// the AES round loop runs once per block and stalls each block's first word.
// A 4-entry queue decouples intake from the cipher, so in_tready drops only
// when the queue is full, e.g. during AES or while out_tready is low.
// Reset (rst_n low, synchronous) clears key, control, counter and queue state.
// When the receiver stalls, the output word holds and the queue fills.
// Depends on aesctr_pkg, aesctr_front, aesctr_queue and aesctr_back.
`default_nettype none

module aes128_ctr_stream_cipher_unit import aesctr_pkg::*; #(
  parameter int QUEUE_DEPTH = AC_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] first_of_message
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  entry_t in_entry, head;
  logic   push, pop, q_full, q_nempty;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  // tag each word with its block counter and position
  aesctr_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .data_byte        (in_tdata),
    .first_of_message (in_tuser),
    .last_of_message  (in_tlast),
    .entry            (in_entry)
  );

  aesctr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_entry  (in_entry),
    .pop       (pop),
    .rd_entry  (head),
    .full      (q_full),
    .not_empty (q_nempty)
  );

  // generate keystream per block and XOR it into each word
  aesctr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head       (head),
    .head_valid (q_nempty),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

`default_nettype wire

@@ rtl/core/aesctr_front.sv @@
// Front end: tracks block counter and byte position, tags each word.
// Depends on aesctr_pkg.
`default_nettype none

module aesctr_front import aesctr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire logic [7:0] data_byte,
  input  wire logic       first_of_message,
  input  wire logic       last_of_message,
  output entry_t          entry
);

  logic [63:0] ctr_r, ctr_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [63:0] ctr_use;
  logic [3:0]  pos_use;

  always_comb begin
    ctr_use = first_of_message ? 64'd0 : ctr_r;
    pos_use = first_of_message ? 4'd0 : pos_r;
    pos_nxt = pos_use + 4'd1;
    ctr_nxt = (pos_use == 4'hf) ? ctr_use + 64'd1 : ctr_use;
    entry.data = data_byte;
    entry.last = last_of_message;
    entry.pos  = pos_use;
    entry.ctr  = ctr_use;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= '0;
      pos_r <= '0;
    end else if (push) begin
      ctr_r <= ctr_nxt;
      pos_r <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/aesctr_queue.sv @@
// Short word queue between the front and back ends.
// Depends on aesctr_pkg.
`default_nettype none

module aesctr_queue import aesctr_pkg::*; #(
  parameter int DEPTH = AC_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  entry_t    wr_entry,
  input  wire logic pop,
  output entry_t    rd_entry,
  output logic      full,
  output logic      not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t          mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [AW:0]     count_r;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full      = (count_r == (AW+1)'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rd_entry  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + (AW+1)'(1);
      else if (pop && !push) count_r <= count_r - (AW+1)'(1);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/aesctr_aes.sv @@
// Round-iterative AES-128 encryption, one round per cycle, keys on the fly.
// Depends on aesctr_pkg.
`default_nettype none

module aesctr_aes import aesctr_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [127:0] key,
  input  wire logic [127:0] blk,
  output aes_stat_t         stat,
  output logic [127:0]      result
);

  logic         busy_r;
  logic [3:0]   rnd_r;
  logic [127:0] st_r, rk_r;
  logic [127:0] rk_nxt, st_nxt;
  logic         last_rnd;

  always_comb begin
    last_rnd    = (rnd_r == 4'(AC_ROUNDS));
    rk_nxt      = key_next(rk_r, rcon(rnd_r));
    st_nxt      = aes_round(st_r, rk_nxt, last_rnd);
    stat.busy   = busy_r;
    stat.done   = busy_r && last_rnd;
    result      = st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      rnd_r  <= 4'd1;
    end else if (busy_r) begin
      busy_r <= !last_rnd;
      rnd_r  <= rnd_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      st_r <= blk ^ key;
      rk_r <= key;
    end else if (busy_r) begin
      st_r <= st_nxt;
      rk_r <= rk_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/aesctr_back.sv @@
// Back end: key registers, keystream generation and the output register.
// Depends on aesctr_pkg, aesctr_aes and the assertion macro header.
`default_nettype none
`include "aes128_ctr_stream_cipher_unit_macros.svh"

module aesctr_back import aesctr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  entry_t           head,
  input  wire logic        head_valid,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last
);

  logic [63:0]  key_hi_r, key_lo_r, nonce_r;
  logic [127:0] ks_r;
  logic         fresh_r;
  logic         out_valid_r;
  logic [7:0]   out_byte_r;
  logic         out_last_r;
  logic         aes_start;
  aes_stat_t    aes_stat;
  logic [127:0] aes_result;
  logic [7:0]   ks_byte;
  logic         head_new_blk;
  logic [63:0]  ctr_le;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
      nonce_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_KEY_HIGH: key_hi_r <= cfg_data;
        CFG_KEY_LOW:  key_lo_r <= cfg_data;
        CFG_NONCE:    nonce_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  aesctr_aes u_aes (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (aes_start),
    .key    ({key_hi_r, key_lo_r}),
    .blk    ({nonce_r, ctr_le}),
    .stat   (aes_stat),
    .result (aes_result)
  );

  always_comb begin
    // counter bytes go out least significant first
    for (int i = 0; i < 8; i++) ctr_le[63 - 8*i -: 8] = head.ctr[8*i +: 8];
    head_new_blk = (head.pos == 4'd0);
    aes_start    = head_valid && head_new_blk && !fresh_r && !aes_stat.busy;
    pop          = head_valid && (!head_new_blk || fresh_r) && (!out_valid_r || out_ready);
    ks_byte      = ks_r[{~head.pos, 3'b000} +: 8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // hold the new block until its first word leaves
      if (aes_stat.done)              fresh_r <= 1'b1;
      else if (pop && head_new_blk)   fresh_r <= 1'b0;
      if (pop)            out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (aes_stat.done) ks_r <= aes_result;
    if (pop) begin
      out_byte_r <= head.data ^ ks_byte;
      out_last_r <= head.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  `AC_ASSERT_IMPL(a_start_idle, clk, rst_n, aes_start, !aes_stat.busy)
  `AC_ASSERT_IMPL(a_pop_fresh, clk, rst_n, pop && head_new_blk, fresh_r)
  `AC_ASSERT_NEXT(a_done_fresh, clk, rst_n, aes_stat.done, fresh_r)

endmodule

`default_nettype wire
